/* rtl/core/two_class_age_ordered_queue_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the two-class age-ordered queue
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_AGE_ORDERED_QUEUE_MACROS_SVH
`define TWO_CLASS_AGE_ORDERED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCAQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tcaq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tcaq assertion failed");

`endif

/* rtl/core/tcaq_pkg.sv */
// ----------------------------------------------------------------------------
// tcaq_pkg
// Shared codes and controller/datapath interface types of the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcaq_pkg;

  localparam int unsigned STAMP_W = 6;

  // command codes
  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_POP_ANY = 2'd1;
  localparam logic [1:0] CMD_POP_DOG = 2'd2;
  localparam logic [1:0] CMD_POP_CAT = 2'd3;

  // item classes
  localparam logic [1:0] CLS_DOG = 2'd0;
  localparam logic [1:0] CLS_CAT = 2'd1;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_CLASS = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load_in;   // capture the accepted item
    logic rd_en;     // read both queue heads
    logic exec_en;   // commit the operation and load the result
  } tcaq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } tcaq_stat_t;

endpackage

`default_nettype wire

/* rtl/core/tcaq_ctrl.sv */
// ----------------------------------------------------------------------------
// tcaq_ctrl
// Sequencer: accept, read heads, execute into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcaq_ctrl
  import tcaq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire tcaq_stat_t stat_i,
  output tcaq_cmd_t       cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        // hold until the previous result has left
        if (stat_i.out_free) begin
          cmd_o.exec_en = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tcaq_dp.sv */
// ----------------------------------------------------------------------------
// tcaq_dp
// Queue storage, pointers, stamp counter, age compare and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcaq_dp
  import tcaq_pkg::*;
#(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned PAYLOAD_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire tcaq_cmd_t               cmd_i,
  output tcaq_stat_t                   stat_o,
  input  wire logic [1:0]              in_command_i,
  input  wire logic [1:0]              in_class_i,
  input  wire logic [PAYLOAD_BITS-1:0] in_payload_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic                         out_popped_valid_o,
  output logic                         out_popped_class_o,
  output logic [PAYLOAD_BITS-1:0]      out_popped_payload_o,
  output logic [1:0]                   out_status_o,
  output logic                         out_dog_empty_o,
  output logic                         out_cat_empty_o,
  output logic                         out_all_empty_o
);

  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

  // captured item
  logic [1:0]              cmd_q, cls_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  // storage
  logic [PAYLOAD_BITS-1:0] dog_pay_mem [DEPTH];
  logic [STAMP_W-1:0]      dog_stm_mem [DEPTH];
  logic [PAYLOAD_BITS-1:0] cat_pay_mem [DEPTH];
  logic [STAMP_W-1:0]      cat_stm_mem [DEPTH];

  logic [PAYLOAD_BITS-1:0] dog_pay_rd_q, cat_pay_rd_q;
  logic [STAMP_W-1:0]      dog_stm_rd_q, cat_stm_rd_q;

  logic [PTR_W-1:0]  dog_head_q, dog_head_d, dog_tail_q, dog_tail_d;
  logic [PTR_W-1:0]  cat_head_q, cat_head_d, cat_tail_q, cat_tail_d;
  logic [FILL_W-1:0] dog_fill_q, dog_fill_d, cat_fill_q, cat_fill_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;

  // result register
  logic                    res_valid_q;
  logic                    res_pvalid_q, res_pclass_q;
  logic [PAYLOAD_BITS-1:0] res_payload_q;
  logic [1:0]              res_status_q;
  logic                    res_dog_empty_q, res_cat_empty_q, res_all_empty_q;

  // decode
  logic               dog_ne, cat_ne, dog_older;
  logic               push_dog, push_cat, take_dog, take_cat;
  logic [STAMP_W-1:0] stamp_diff;
  logic [1:0]         status;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q <= in_command_i;
      cls_q <= in_class_i;
      pay_q <= in_payload_i;
    end
  end

  always_comb begin
    dog_ne     = (dog_fill_q != '0);
    cat_ne     = (cat_fill_q != '0);
    stamp_diff = dog_stm_rd_q - cat_stm_rd_q;
    dog_older  = stamp_diff[STAMP_W-1];
    push_dog   = 1'b0;
    push_cat   = 1'b0;
    take_dog   = 1'b0;
    take_cat   = 1'b0;
    status     = ST_OK;
    unique case (cmd_q)
      CMD_PUSH: begin
        if (cls_q == CLS_DOG) begin
          if (dog_fill_q == FILL_MAX) status = ST_FULL;
          else                        push_dog = 1'b1;
        end else if (cls_q == CLS_CAT) begin
          if (cat_fill_q == FILL_MAX) status = ST_FULL;
          else                        push_cat = 1'b1;
        end else begin
          status = ST_BAD_CLASS;
        end
      end
      CMD_POP_ANY: begin
        if (dog_ne && cat_ne) begin
          take_dog = dog_older;
          take_cat = !dog_older;
        end else if (cat_ne) begin
          take_cat = 1'b1;
        end else if (dog_ne) begin
          take_dog = 1'b1;
        end else begin
          status = ST_EMPTY;
        end
      end
      CMD_POP_DOG: begin
        if (dog_ne) take_dog = 1'b1;
        else        status   = ST_EMPTY;
      end
      CMD_POP_CAT: begin
        if (cat_ne) take_cat = 1'b1;
        else        status   = ST_EMPTY;
      end
      default: begin
        status = ST_EMPTY;
      end
    endcase
  end

  always_comb begin
    dog_head_d = take_dog ? next_ptr(dog_head_q) : dog_head_q;
    cat_head_d = take_cat ? next_ptr(cat_head_q) : cat_head_q;
    dog_tail_d = push_dog ? next_ptr(dog_tail_q) : dog_tail_q;
    cat_tail_d = push_cat ? next_ptr(cat_tail_q) : cat_tail_q;
    dog_fill_d = dog_fill_q;
    cat_fill_d = cat_fill_q;
    if (push_dog) dog_fill_d = dog_fill_q + FILL_W'(1);
    if (take_dog) dog_fill_d = dog_fill_q - FILL_W'(1);
    if (push_cat) cat_fill_d = cat_fill_q + FILL_W'(1);
    if (take_cat) cat_fill_d = cat_fill_q - FILL_W'(1);
    stamp_d = (push_dog || push_cat) ? stamp_q + STAMP_W'(1) : stamp_q;
  end

  // storage writes at the tail, registered reads at the head
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_en && push_dog) begin
      dog_pay_mem[dog_tail_q] <= pay_q;
      dog_stm_mem[dog_tail_q] <= stamp_q;
    end
    if (cmd_i.exec_en && push_cat) begin
      cat_pay_mem[cat_tail_q] <= pay_q;
      cat_stm_mem[cat_tail_q] <= stamp_q;
    end
    if (cmd_i.rd_en) begin
      dog_pay_rd_q <= dog_pay_mem[dog_head_q];
      dog_stm_rd_q <= dog_stm_mem[dog_head_q];
      cat_pay_rd_q <= cat_pay_mem[cat_head_q];
      cat_stm_rd_q <= cat_stm_mem[cat_head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dog_head_q <= '0;
      dog_tail_q <= '0;
      dog_fill_q <= '0;
      cat_head_q <= '0;
      cat_tail_q <= '0;
      cat_fill_q <= '0;
      stamp_q    <= '0;
    end else if (cmd_i.exec_en) begin
      dog_head_q <= dog_head_d;
      dog_tail_q <= dog_tail_d;
      dog_fill_q <= dog_fill_d;
      cat_head_q <= cat_head_d;
      cat_tail_q <= cat_tail_d;
      cat_fill_q <= cat_fill_d;
      stamp_q    <= stamp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.exec_en) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_en) begin
      res_pvalid_q    <= take_dog | take_cat;
      res_pclass_q    <= take_cat;
      res_payload_q   <= take_dog ? dog_pay_rd_q : (take_cat ? cat_pay_rd_q : '0);
      res_status_q    <= status;
      res_dog_empty_q <= (dog_fill_d == '0);
      res_cat_empty_q <= (cat_fill_d == '0);
      res_all_empty_q <= (dog_fill_d == '0) && (cat_fill_d == '0);
    end
  end

  assign stat_o.out_free      = !res_valid_q || out_ready_i;
  assign out_valid_o          = res_valid_q;
  assign out_popped_valid_o   = res_pvalid_q;
  assign out_popped_class_o   = res_pclass_q;
  assign out_popped_payload_o = res_payload_q;
  assign out_status_o         = res_status_q;
  assign out_dog_empty_o      = res_dog_empty_q;
  assign out_cat_empty_o      = res_cat_empty_q;
  assign out_all_empty_o      = res_all_empty_q;

endmodule

`default_nettype wire

/* rtl/core/two_class_age_ordered_queue.sv */
// Flow: an accepted item goes through the head read, then execute into the result register;
//   execute waits while the previous result is still stalled in the output register.
// One item at a time: a new item is accepted once the previous one has executed;
//   the memory head read is registered, ahead of the age compare and pointer update.
// A new item is taken while the previous result still waits in the output register.
// Reset (rst_ni low, asynchronous) empties both queues and clears the stamp;
//   queue storage is not cleared; head reads of an empty queue are never used.
// ----------------------------------------------------------------------------
// two_class_age_ordered_queue
// Two FIFOs (dog, cat) sharing one 6-bit arrival stamp; pops take the older
// head, or the head of a named class, with status and empty flags per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_class_age_ordered_queue
  import tcaq_pkg::*;
#(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned PAYLOAD_BITS = 16,
  localparam int unsigned DATA_W      = ((PAYLOAD_BITS + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input items
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [DATA_W-1:0] s_axis_tdata,  // item_payload, zero padded
  input  wire logic [3:0]        s_axis_tuser,  // command[1:0], item_class[3:2]
  // result items
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [DATA_W-1:0]      m_axis_tdata,  // popped_payload, zero padded
  output logic [6:0]             m_axis_tuser   // popped_valid[0], popped_class[1],
                                                // status_code[3:2], dog_empty[4],
                                                // cat_empty[5], all_empty[6]
);

  tcaq_cmd_t  cmd;
  tcaq_stat_t stat;

  logic                    popped_valid, popped_class;
  logic [PAYLOAD_BITS-1:0] popped_payload;
  logic [1:0]              status_code;
  logic                    dog_empty, cat_empty, all_empty;

  // Controller: walks one item through capture -> head read -> execute.
  tcaq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: storage, pointers, stamp, age compare and result register.
  tcaq_dp #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .in_command_i         (s_axis_tuser[1:0]),
    .in_class_i           (s_axis_tuser[3:2]),
    .in_payload_i         (s_axis_tdata[PAYLOAD_BITS-1:0]),
    .out_valid_o          (m_axis_tvalid),
    .out_ready_i          (m_axis_tready),
    .out_popped_valid_o   (popped_valid),
    .out_popped_class_o   (popped_class),
    .out_popped_payload_o (popped_payload),
    .out_status_o         (status_code),
    .out_dog_empty_o      (dog_empty),
    .out_cat_empty_o      (cat_empty),
    .out_all_empty_o      (all_empty)
  );

  // Pack the result item; payload is zero extended to whole bytes.
  assign m_axis_tdata = DATA_W'(popped_payload);
  assign m_axis_tuser = {all_empty, cat_empty, dog_empty, status_code,
                         popped_class, popped_valid};

endmodule

`default_nettype wire

/* rtl/core/tcaq_checker.sv */
// ----------------------------------------------------------------------------
// tcaq_checker
// Port-level checks of the queue's result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "two_class_age_ordered_queue_macros.svh"

module tcaq_checker
  import tcaq_pkg::*;
#(
  parameter int unsigned DATA_W = 16
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [DATA_W-1:0] m_axis_tdata,
  input wire logic [6:0]        m_axis_tuser
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // a stalled result stays offered
  `TCAQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // all_empty is the conjunction of the per-class flags
  `TCAQ_ASSERT_NOW(a_all_empty, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser[6] == (m_axis_tuser[4] && m_axis_tuser[5]))
  // a returned entry always carries status ok
  `TCAQ_ASSERT_NOW(a_pop_ok, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[3:2] == ST_OK)
  // no entry returned: class and payload are zero
  `TCAQ_ASSERT_NOW(a_no_pop_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tuser[1] == 1'b0 && m_axis_tdata == '0)
  // no back-to-back accepts: ready is low after an accept
  `TCAQ_ASSERT_NEXT(a_no_b2b, clk_i, rst_ni, in_acc, !s_axis_tready)

endmodule

bind two_class_age_ordered_queue tcaq_checker #(.DATA_W(DATA_W)) u_tcaq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
